[hdl/asc_pkg.sv]
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants of the Ackermann steering step
// Holds the micro-op codes, controller/datapath command and status structs,
// register indexes, fixed-point limits and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int ANG_FRAC = 30;          // CORDIC angles are Q2.30
    localparam int CW       = 36;          // CORDIC word width
    localparam int MW       = 34;          // multiplier operand width
    localparam int NW       = 64;          // dividend / product width
    localparam int DW       = 34;          // divisor width
    localparam int TAB_LEN  = 30;
    localparam int TAB_IW   = 5;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 168;

    localparam logic signed [CW-1:0] ONE_Q30     = 36'sd1073741824;
    localparam logic signed [63:0]   HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [31:0]   S32_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]   S32_MIN     = 32'sh8000_0000;

    localparam logic [1:0] CFG_WHEEL_BASE   = 2'd0;
    localparam logic [1:0] CFG_WHEEL_RADIUS = 2'd1;
    localparam logic [1:0] CFG_TRACK_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_STEP_TIME    = 2'd3;

    localparam logic [30:0] WHEEL_BASE_RST   = 31'd65536;
    localparam logic [30:0] WHEEL_RADIUS_RST = 31'd16384;
    localparam logic [30:0] TRACK_WIDTH_RST  = 31'd32768;
    localparam logic [16:0] STEP_TIME_RST    = 17'd655;

    localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
    };

    typedef enum logic [4:0] {
        OP_NONE, OP_ROT, OP_MULX, OP_DIVR, OP_RPM, OP_ATM, OP_ATP, OP_MULW,
        OP_SATW, OP_RATE, OP_MULD, OP_DIVD, OP_MULO, OP_DIVO, OP_MULS, OP_DIVS,
        OP_FIN
    } asc_op_t;

    typedef struct packed {
        logic    take;
        logic    start;
        asc_op_t op;
        logic    load_out;
    } asc_cmd_t;

    typedef struct packed {
        logic done;
        logic straight;
        logic out_free;
    } asc_stat_t;

    // clamp to the signed 32-bit range; bit 32 flags a clamp
    function automatic logic [32:0] sat34(input logic signed [33:0] v);
        logic [32:0] r;
        if (v > 34'sd2147483647) begin
            r = {1'b1, S32_MAX};
        end else if (v < -34'sd2147483648) begin
            r = {1'b1, S32_MIN};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

[hdl/asc_div.sv]
// ----------------------------------------------------------------------------
// asc_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle; truncates
// toward zero and clamps the quotient to the signed 32-bit range.
// ----------------------------------------------------------------------------
module asc_div import asc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 done,
    output logic signed [31:0]   quo,
    output logic                 ovf
);

    localparam int CNT_W = $clog2(NW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW - 1);

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    dstate_t          state_reg;
    logic [NW-1:0]    n_reg;
    logic [NW-1:0]    q_reg;
    logic [DW-1:0]    d_reg;
    logic [DW-1:0]    rem_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic signed [31:0] quo_reg;
    logic             ovf_reg;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          qbit;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] q_next;

    always_comb begin
        shifted  = {rem_reg, n_reg[NW-1]};
        diff     = shifted - {1'b0, d_reg};
        qbit     = !diff[DW];
        rem_next = qbit ? diff[DW-1:0] : shifted[DW-1:0];
        q_next   = {q_reg[NW-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            n_reg     <= '0;
            q_reg     <= '0;
            d_reg     <= '0;
            rem_reg   <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            quo_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        n_reg     <= num[NW-1] ? NW'(-num) : NW'(num);
                        d_reg     <= den[DW-1] ? DW'(-den) : DW'(den);
                        neg_reg   <= num[NW-1] ^ den[DW-1];
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    rem_reg <= rem_next;
                    q_reg   <= q_next;
                    n_reg   <= {n_reg[NW-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST) begin
                        state_reg <= D_IDLE;
                        done_reg  <= 1'b1;
                        if (!neg_reg) begin
                            if (q_next > NW'(32'h7FFF_FFFF)) begin
                                quo_reg <= S32_MAX;
                                ovf_reg <= 1'b1;
                            end else begin
                                quo_reg <= q_next[31:0];
                                ovf_reg <= 1'b0;
                            end
                        end else begin
                            if (q_next > NW'(33'h0_8000_0000)) begin
                                quo_reg <= S32_MIN;
                                ovf_reg <= 1'b1;
                            end else begin
                                quo_reg <= -q_next[31:0];
                                ovf_reg <= 1'b0;
                            end
                        end
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule

[hdl/asc_cordic.sv]
// ----------------------------------------------------------------------------
// asc_cordic: shared serial CORDIC
// Rotation mode gives cos and sin of an angle; vectoring mode gives the
// arctangent of a ratio of magnitudes after a left-shift normalization.
// ----------------------------------------------------------------------------
module asc_cordic import asc_pkg::*; #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start_rot,
    input  logic                 start_vec,
    input  logic signed [CW-1:0] z_in,
    input  logic        [30:0]   vn_in,
    input  logic signed [31:0]   vd_in,
    output logic                 done,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [31:0]   ang_out
);

    localparam int AS = ANG_FRAC - FRAC_BITS;
    localparam int IW = $clog2(CORDIC_STEPS);
    localparam logic [IW-1:0] I_LAST = IW'(CORDIC_STEPS - 1);
    localparam logic signed [CW-1:0] RND   = CW'(1) <<< (AS - 1);
    localparam logic signed [CW-1:0] NORM_LIM = CW'(1) <<< 29;

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} cstate_t;

    cstate_t              state_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic                 vec_reg;
    logic                 neg_reg;
    logic [IW-1:0]        i_reg;
    logic                 done_reg;
    logic signed [31:0]   ang_reg;

    logic signed [CW-1:0] t, dx, dy, x_nx, y_nx, z_nx, zr;
    logic                 up;

    always_comb begin
        t  = CW'(ATAN_TAB[TAB_IW'(i_reg)]);
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        up = vec_reg ? (y_reg > 0) : (z_reg >= 0);
        if (up ^ vec_reg) begin
            x_nx = x_reg - dx;
            y_nx = y_reg + dy;
        end else begin
            x_nx = x_reg + dx;
            y_nx = y_reg - dy;
        end
        z_nx = (up ^ vec_reg) ? z_reg - t : z_reg + t;
        zr   = (z_nx + RND) >>> AS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            vec_reg   <= 1'b0;
            neg_reg   <= 1'b0;
            i_reg     <= '0;
            ang_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE: begin
                    i_reg <= '0;
                    if (start_rot) begin
                        x_reg     <= ONE_Q30;
                        y_reg     <= '0;
                        z_reg     <= z_in;
                        vec_reg   <= 1'b0;
                        state_reg <= C_ITER;
                    end else if (start_vec) begin
                        x_reg   <= vd_in[31] ? -CW'(vd_in) : CW'(vd_in);
                        y_reg   <= CW'(vn_in);
                        z_reg   <= '0;
                        vec_reg <= 1'b1;
                        neg_reg <= vd_in[31];
                        // zero numerator: angle is zero
                        if (vn_in == '0) begin
                            ang_reg  <= '0;
                            done_reg <= 1'b1;
                        end else begin
                            state_reg <= C_NORM;
                        end
                    end
                end
                C_NORM: begin
                    if (x_reg < NORM_LIM && y_reg < NORM_LIM) begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end else begin
                        state_reg <= C_ITER;
                    end
                end
                C_ITER: begin
                    x_reg <= x_nx;
                    y_reg <= y_nx;
                    z_reg <= z_nx;
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == I_LAST) begin
                        state_reg <= C_IDLE;
                        done_reg  <= 1'b1;
                        ang_reg   <= neg_reg ? -zr[31:0] : zr[31:0];
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign ang_out = ang_reg;

endmodule

[hdl/asc_dpath.sv]
// ----------------------------------------------------------------------------
// asc_dpath: datapath of the Ackermann steering step
// Config registers, kept state, one shared multiplier, the CORDIC unit,
// the divider, the saturation logic and the output register.
// ----------------------------------------------------------------------------
module asc_dpath import asc_pkg::*; #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [30:0]      cfg_wdata,
    input  logic [IN_W-1:0]  s_tdata,
    input  asc_cmd_t         cmd,
    output asc_stat_t        stat,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tuser
);

    localparam int AS = ANG_FRAC - FRAC_BITS;
    localparam logic signed [63:0] HP = (HALF_PI_Q30 + (64'sd1 <<< (AS - 1))) >>> AS;
    localparam logic signed [31:0] HP32 = HP[31:0];
    localparam logic signed [63:0] MAX64 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] MIN64 = -64'sh0000_0000_8000_0000;

    logic [30:0] wheel_base_reg, wheel_radius_reg, track_width_reg;
    logic [16:0] step_time_reg;

    logic signed [17:0] cmd_reg;
    logic signed [23:0] inc_reg;
    logic               flag_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] r_reg, rm_reg, rp_reg, am_reg, ap_reg;
    logic signed [31:0] wrdt_reg, driven_reg, delta_reg;
    logic signed [31:0] heading_reg, inner_rate_reg, outer_rate_reg;
    logic        [30:0] speed_reg;
    logic signed [17:0] inner_ang_reg, outer_ang_reg;
    logic               done_reg;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic               out_user_reg;

    // input capture and clamp to a quarter turn
    logic signed [31:0] cmd_in;
    logic               cmd_hi, cmd_lo;
    logic signed [17:0] cmd_cl;
    logic               pos;

    always_comb begin
        cmd_in = 32'(signed'(s_tdata[17:0]));
        cmd_hi = cmd_in > HP32;
        cmd_lo = cmd_in < -HP32;
        if (cmd_hi) begin
            cmd_cl = HP32[17:0];
        end else if (cmd_lo) begin
            cmd_cl = -HP32[17:0];
        end else begin
            cmd_cl = s_tdata[17:0];
        end
        pos = !cmd_reg[17];
    end

    // op classes
    logic is_div, is_vec, is_mul, single;

    always_comb begin
        is_div = cmd.op == OP_DIVR || cmd.op == OP_DIVD || cmd.op == OP_DIVO
              || cmd.op == OP_DIVS;
        is_vec = cmd.op == OP_ATM || cmd.op == OP_ATP;
        is_mul = cmd.op == OP_MULX || cmd.op == OP_MULW || cmd.op == OP_MULD
              || cmd.op == OP_MULO || cmd.op == OP_MULS;
        single = is_mul || cmd.op == OP_RPM || cmd.op == OP_SATW
              || cmd.op == OP_RATE || cmd.op == OP_FIN;
    end

    // CORDIC
    logic                 cor_done;
    logic signed [CW-1:0] cor_x, cor_y;
    logic signed [31:0]   cor_ang;
    logic signed [31:0]   vec_d;
    logic                 vz;
    logic signed [CW-1:0] z0;

    assign vec_d = (cmd.op == OP_ATP) ? rp_reg : rm_reg;
    assign vz    = vec_d == '0;
    assign z0    = CW'(cmd_reg) <<< AS;

    asc_cordic #(
        .FRAC_BITS   (FRAC_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_rot(cmd.start && cmd.op == OP_ROT),
        .start_vec(cmd.start && is_vec && !vz),
        .z_in     (z0),
        .vn_in    (wheel_base_reg),
        .vd_in    (vec_d),
        .done     (cor_done),
        .x_out    (cor_x),
        .y_out    (cor_y),
        .ang_out  (cor_ang)
    );

    // shared multiplier
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;

    always_comb begin
        unique case (cmd.op)
            OP_MULX: begin
                mul_a = MW'(wheel_base_reg);
                mul_b = cor_x[MW-1:0];
            end
            OP_MULW: begin
                mul_a = MW'(wheel_radius_reg);
                mul_b = MW'(step_time_reg);
            end
            OP_MULD: begin
                mul_a = MW'(wrdt_reg);
                mul_b = MW'(driven_reg);
            end
            OP_MULO: begin
                mul_a = MW'(delta_reg);
                mul_b = MW'(rm_reg);
            end
            OP_MULS: begin
                mul_a = MW'(r_reg);
                mul_b = MW'(delta_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // divider
    logic signed [DW-1:0] div_den;
    logic                 dz;
    logic                 div_done, div_ovf;
    logic signed [31:0]   div_quo;

    always_comb begin
        unique case (cmd.op)
            OP_DIVR: div_den = cor_y[DW-1:0];
            OP_DIVD: div_den = DW'(rp_reg);
            OP_DIVO: div_den = DW'(wrdt_reg);
            OP_DIVS: div_den = DW'(step_time_reg);
            default: div_den = '0;
        endcase
        dz = div_den == '0;
    end

    asc_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.start && is_div && !dz),
        .num    (prod_reg),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_quo),
        .ovf    (div_ovf)
    );

    // quotient: from the divider, or the clamped value for a zero divisor
    logic signed [31:0] dres;
    logic               dovf, dwr;
    logic [30:0]        spd_abs;
    logic               spd_ovf;

    always_comb begin
        if (div_done) begin
            dres = div_quo;
            dovf = div_ovf;
        end else begin
            dovf = 1'b1;
            priority if (cmd.op == OP_DIVR) begin
                dres = pos ? S32_MAX : S32_MIN;
            end else if (prod_reg > 0) begin
                dres = S32_MAX;
            end else if (prod_reg < 0) begin
                dres = S32_MIN;
            end else begin
                dres = '0;
            end
        end
        dwr = div_done || (cmd.start && is_div && dz);
        spd_ovf = dres == S32_MIN;
        if (spd_ovf) begin
            spd_abs = S32_MAX[30:0];
        end else if (dres < 0) begin
            spd_abs = 31'(-dres);
        end else begin
            spd_abs = dres[30:0];
        end
    end

    // combinational results of the RPM, SATW and RATE ops
    logic [32:0]        rm_s, rp_s, rate_s;
    logic signed [33:0] h34, r34;
    logic signed [63:0] wsh;

    always_comb begin
        h34    = 34'(track_width_reg >> 1);
        r34    = 34'(r_reg);
        rm_s   = sat34(r34 - h34);
        rp_s   = sat34(r34 + h34);
        rate_s = sat34(34'(pos ? outer_rate_reg : inner_rate_reg) + 34'(inc_reg));
        wsh    = prod_reg >>> FRAC_BITS;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_base_reg   <= WHEEL_BASE_RST;
            wheel_radius_reg <= WHEEL_RADIUS_RST;
            track_width_reg  <= TRACK_WIDTH_RST;
            step_time_reg    <= STEP_TIME_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_WHEEL_BASE:   wheel_base_reg   <= cfg_wdata;
                CFG_WHEEL_RADIUS: wheel_radius_reg <= cfg_wdata;
                CFG_TRACK_WIDTH:  track_width_reg  <= cfg_wdata;
                CFG_STEP_TIME:    step_time_reg    <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // work registers and kept state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg        <= '0;
            inc_reg        <= '0;
            flag_reg       <= 1'b0;
            prod_reg       <= '0;
            r_reg          <= '0;
            rm_reg         <= '0;
            rp_reg         <= '0;
            am_reg         <= '0;
            ap_reg         <= '0;
            wrdt_reg       <= '0;
            driven_reg     <= '0;
            delta_reg      <= '0;
            heading_reg    <= '0;
            speed_reg      <= '0;
            inner_ang_reg  <= '0;
            outer_ang_reg  <= '0;
            inner_rate_reg <= '0;
            outer_rate_reg <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_user_reg   <= 1'b0;
        end else begin
            done_reg <= (cmd.start && single) || (cmd.start && is_div && dz)
                     || (cmd.start && is_vec && vz) || div_done || cor_done;

            if (cmd.take) begin
                cmd_reg  <= cmd_cl;
                inc_reg  <= s_tdata[41:18];
                flag_reg <= cmd_hi || cmd_lo;
            end

            if (cmd.start) begin
                if (is_mul) begin
                    prod_reg <= mul_p[63:0];
                end
                case (cmd.op)
                    OP_RPM: begin
                        rm_reg <= rm_s[31:0];
                        rp_reg <= rp_s[31:0];
                        if (rm_s[32] || rp_s[32]) flag_reg <= 1'b1;
                    end
                    OP_ATM, OP_ATP: begin
                        // zero divisor: quarter turn, or zero for a zero numerator
                        if (vz) begin
                            flag_reg <= 1'b1;
                            if (cmd.op == OP_ATM) begin
                                am_reg <= (wheel_base_reg == '0) ? '0 : HP32;
                            end else begin
                                ap_reg <= (wheel_base_reg == '0) ? '0 : HP32;
                            end
                        end
                    end
                    OP_SATW: begin
                        if (wsh > MAX64) begin
                            wrdt_reg <= S32_MAX;
                            flag_reg <= 1'b1;
                        end else if (wsh < MIN64) begin
                            wrdt_reg <= S32_MIN;
                            flag_reg <= 1'b1;
                        end else begin
                            wrdt_reg <= wsh[31:0];
                        end
                    end
                    OP_RATE: begin
                        driven_reg <= rate_s[31:0];
                        if (rate_s[32]) flag_reg <= 1'b1;
                        if (pos) begin
                            inner_ang_reg  <= am_reg[17:0];
                            outer_ang_reg  <= ap_reg[17:0];
                            outer_rate_reg <= rate_s[31:0];
                        end else begin
                            outer_ang_reg  <= am_reg[17:0];
                            inner_ang_reg  <= ap_reg[17:0];
                            inner_rate_reg <= rate_s[31:0];
                        end
                    end
                    OP_FIN: begin
                        if (cmd_reg == '0) begin
                            speed_reg <= '0;
                        end else begin
                            heading_reg <= heading_reg + delta_reg;
                        end
                    end
                    default: ;
                endcase
            end

            if (dwr) begin
                if (dovf) flag_reg <= 1'b1;
                case (cmd.op)
                    OP_DIVR: r_reg     <= dres;
                    OP_DIVD: delta_reg <= dres;
                    OP_DIVO: begin
                        if (pos) begin
                            inner_rate_reg <= dres;
                        end else begin
                            outer_rate_reg <= dres;
                        end
                    end
                    OP_DIVS: begin
                        speed_reg <= spd_abs;
                        if (spd_ovf) flag_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if (cor_done) begin
                case (cmd.op)
                    OP_ATM:  am_reg <= cor_ang;
                    OP_ATP:  ap_reg <= cor_ang;
                    default: ;
                endcase
            end

            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {5'b0, outer_rate_reg, inner_rate_reg, outer_ang_reg,
                                  inner_ang_reg, speed_reg, heading_reg};
                out_user_reg  <= flag_reg;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.done     = done_reg;
    assign stat.straight = cmd_reg == '0;
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

[hdl/asc_ctrl.sv]
// ----------------------------------------------------------------------------
// asc_ctrl: sequencer of the Ackermann steering step
// Takes an item, steps the datapath through its op list and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module asc_ctrl import asc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  asc_stat_t stat,
    output asc_cmd_t  cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_WORK, ST_OUT} state_t;

    state_t  state_reg;
    logic    ready_reg;
    logic    start_reg;
    logic    load_reg;
    asc_op_t op_reg;
    logic    take;

    function automatic asc_op_t next_op(input asc_op_t op);
        asc_op_t n;
        unique case (op)
            OP_ROT:  n = OP_MULX;
            OP_MULX: n = OP_DIVR;
            OP_DIVR: n = OP_RPM;
            OP_RPM:  n = OP_ATM;
            OP_ATM:  n = OP_ATP;
            OP_ATP:  n = OP_MULW;
            OP_MULW: n = OP_SATW;
            OP_SATW: n = OP_RATE;
            OP_RATE: n = OP_MULD;
            OP_MULD: n = OP_DIVD;
            OP_DIVD: n = OP_MULO;
            OP_MULO: n = OP_DIVO;
            OP_DIVO: n = OP_MULS;
            OP_MULS: n = OP_DIVS;
            default: n = OP_FIN;
        endcase
        return n;
    endfunction

    assign take = s_tvalid && ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
            start_reg <= 1'b0;
            load_reg  <= 1'b0;
            op_reg    <= OP_NONE;
        end else begin
            start_reg <= 1'b0;
            load_reg  <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        ready_reg <= 1'b0;
                        state_reg <= ST_CHECK;
                    end else begin
                        ready_reg <= 1'b1;
                    end
                end
                ST_CHECK: begin
                    op_reg    <= stat.straight ? OP_FIN : OP_ROT;
                    start_reg <= 1'b1;
                    state_reg <= ST_WORK;
                end
                ST_WORK: begin
                    if (stat.done) begin
                        if (op_reg == OP_FIN) begin
                            state_reg <= ST_OUT;
                        end else begin
                            op_reg    <= next_op(op_reg);
                            start_reg <= 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (stat.out_free) begin
                        load_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready     = ready_reg;
    assign cmd.take     = take;
    assign cmd.start    = start_reg;
    assign cmd.op       = op_reg;
    assign cmd.load_out = load_reg;

endmodule

[hdl/ackermann_steering_step.sv]
// ----------------------------------------------------------------------------
// ackermann_steering_step: fixed-point Ackermann steering kinematics
// One steering command and wheel-rate increment in, one vehicle state
// update out: heading, speed, steer angles and wheel rates.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  s_*      in   s_tvalid / s_tready   s_tdata: steer_cmd, rate_step
//  m_*      out  m_tvalid / m_tready   m_tdata: state update, m_tuser: saturated
//  cfg_*    in   cfg_we                cfg_addr, cfg_wdata (no read-back)
//
//  An item runs four divisions, one rotation pass and two vectoring passes,
//  each vectoring pass after its left-shift normalization, with the multiply
//  and update ops between them and the steps to accept and load the item.
//  A zero divisor skips its division; a straight command (zero) goes straight to the final op.
//  Reset is synchronous on aresetn low; s_tready rises in the cycle after aresetn is released.
//  The output register holds a result until taken; the next item is accepted
//  and worked on meanwhile, and waits only to be loaded out.
//
module ackermann_steering_step import asc_pkg::*; #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    // config writes: 0 wheel base, 1 wheel radius, 2 track width, 3 step time
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [30:0]      cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // [17:0] steer_cmd, [41:18] rate_step, [47:42] zero
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // [31:0] heading_out, [62:32] speed_out, [80:63] inner_angle_out,
    // [98:81] outer_angle_out, [130:99] inner_rate_out,
    // [162:131] outer_rate_out, [167:163] zero
    output logic [OUT_W-1:0] m_tdata,
    // [0] saturated
    output logic             m_tuser
);

    asc_cmd_t  cmd;
    asc_stat_t stat;

    // sequencer: accept, step through ops, load out
    asc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic, kept state and output register
    asc_dpath #(
        .FRAC_BITS   (FRAC_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
